[rtl/core/cpts_pkg.sv]
// Shared types, register map and digit helpers for the clock panel time setter.
package cpts_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int S_TDATA_BITS  = 56;
    localparam int M_TDATA_BITS  = 40;

    localparam logic [1:0] REG_BLINK_PERIOD    = 2'd0;
    localparam logic [1:0] REG_SETTING_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_REFRESH_PERIOD  = 2'd2;
    localparam logic [1:0] REG_SHUTDOWN_DELAY  = 2'd3;

    localparam logic [15:0] BLINK_PERIOD_RST    = 16'd500;
    localparam logic [15:0] SETTING_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] REFRESH_PERIOD_RST  = 16'd500;
    localparam logic [15:0] SHUTDOWN_DELAY_RST  = 16'd1000;

    localparam logic [2:0] SEL_NONE       = 3'd0;
    localparam logic [2:0] SEL_HOUR_TENS  = 3'd1;
    localparam logic [2:0] SEL_HOUR_UNITS = 3'd2;
    localparam logic [2:0] SEL_MIN_TENS   = 3'd3;
    localparam logic [2:0] SEL_MIN_UNITS  = 3'd4;

    localparam logic [1:0] DOTS_UPPER = 2'b01;
    localparam logic [1:0] DOTS_LOWER = 2'b10;
    localparam logic [1:0] DOTS_BOTH  = 2'b11;

    localparam logic [4:0] HOURS_MAX  = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] HALF_MIN   = 6'd30;

    typedef struct packed {
        logic [15:0] blink_period_ms;
        logic [15:0] setting_timeout_ms;
        logic [15:0] refresh_period_ms;
        logic [15:0] shutdown_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_up;
        logic        button_down;
        logic [4:0]  cur_hours;
        logic [5:0]  cur_minutes;
        logic [5:0]  cur_seconds;
        logic        power_lost;
    } in_item_t;

    typedef struct packed {
        logic       mask_valid;
        logic [3:0] digit_mask;
        logic       set_valid;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] set_seconds;
        logic       show_valid;
        logic [4:0] show_hours;
        logic [5:0] show_minutes;
        logic [1:0] dots;
        logic       shutdown_request;
    } result_t;

    function automatic logic [1:0] hour_tens(input logic [4:0] h);
        return (h >= 5'd20) ? 2'd2 : ((h >= 5'd10) ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [2:0] minute_tens(input logic [5:0] m);
        logic [2:0] t;
        t = 3'd0;
        if (m >= 6'd10) t = 3'd1;
        if (m >= 6'd20) t = 3'd2;
        if (m >= 6'd30) t = 3'd3;
        if (m >= 6'd40) t = 3'd4;
        if (m >= 6'd50) t = 3'd5;
        return t;
    endfunction

endpackage

[rtl/core/cpts_cfg.sv]
// Configuration register file behind the APB-style port.
module cpts_cfg import cpts_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period_ms    <= BLINK_PERIOD_RST;
            cfg_reg.setting_timeout_ms <= SETTING_TIMEOUT_RST;
            cfg_reg.refresh_period_ms  <= REFRESH_PERIOD_RST;
            cfg_reg.shutdown_delay_ms  <= SHUTDOWN_DELAY_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BLINK_PERIOD:    cfg_reg.blink_period_ms    <= pwdata[15:0];
                REG_SETTING_TIMEOUT: cfg_reg.setting_timeout_ms <= pwdata[15:0];
                REG_REFRESH_PERIOD:  cfg_reg.refresh_period_ms  <= pwdata[15:0];
                REG_SHUTDOWN_DELAY:  cfg_reg.shutdown_delay_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BLINK_PERIOD:    prdata = {16'd0, cfg_reg.blink_period_ms};
            REG_SETTING_TIMEOUT: prdata = {16'd0, cfg_reg.setting_timeout_ms};
            REG_REFRESH_PERIOD:  prdata = {16'd0, cfg_reg.refresh_period_ms};
            REG_SHUTDOWN_DELAY:  prdata = {16'd0, cfg_reg.shutdown_delay_ms};
            default:             prdata = '0;
        endcase
    end

endmodule

[rtl/core/cpts_core.sv]
// Poll evaluation: selection, blink, time set, refresh and power watch state.
module cpts_core import cpts_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  in_item_t item,
    input  cfg_t     cfg,
    output result_t  res
);

    logic [2:0]            sel_reg, sel_next, sel_up;
    logic                  blink_phase_reg, blink_phase_next;
    logic                  dot_phase_reg, dot_phase_next;
    logic [STAMP_BITS-1:0] blink_stamp_reg, blink_stamp_next;
    logic [STAMP_BITS-1:0] setting_stamp_reg, setting_stamp_next;
    logic [STAMP_BITS-1:0] refresh_stamp_reg, refresh_stamp_next;
    logic [STAMP_BITS-1:0] power_ok_stamp_reg, power_ok_stamp_next;

    logic [STAMP_BITS-1:0] now_s;
    logic [STAMP_BITS-1:0] blink_elapsed, setting_elapsed, refresh_elapsed, power_elapsed;
    logic                  blink_due, refresh_due;
    logic [1:0]            digit_sel;
    logic [4:0]            hours_c;
    logic [5:0]            minutes_c, seconds_c, sec_show;
    logic [1:0]            ht, nht;
    logic [3:0]            hu, nhu, mu, nmu;
    logic [2:0]            mt, nmt;

    assign now_s           = STAMP_BITS'(item.now_ms);
    assign blink_elapsed   = now_s - blink_stamp_reg;
    assign setting_elapsed = now_s - setting_stamp_reg;
    assign refresh_elapsed = now_s - refresh_stamp_reg;
    assign power_elapsed   = now_s - power_ok_stamp_reg;

    assign blink_due = !((blink_stamp_reg != '0) &&
                         (blink_elapsed < STAMP_BITS'(cfg.blink_period_ms)));
    assign refresh_due = !((refresh_stamp_reg != '0) &&
                           (refresh_elapsed < STAMP_BITS'(cfg.refresh_period_ms)));

    assign digit_sel = 2'(sel_reg - 3'd1);

    // split the clamped time into decimal digits
    assign hours_c   = (item.cur_hours > HOURS_MAX) ? HOURS_MAX : item.cur_hours;
    assign minutes_c = (item.cur_minutes > MINUTE_MAX) ? MINUTE_MAX : item.cur_minutes;
    assign seconds_c = (item.cur_seconds > MINUTE_MAX) ? MINUTE_MAX : item.cur_seconds;
    assign ht = hour_tens(hours_c);
    assign hu = 4'(hours_c - 5'(ht) * 5'd10);
    assign mt = minute_tens(minutes_c);
    assign mu = 4'(minutes_c - 6'(mt) * 6'd10);

    assign sel_up = !item.button_up ? sel_reg :
                    ((sel_reg == SEL_MIN_UNITS) ? SEL_NONE : sel_reg + 3'd1);

    always_comb begin
        nht = ht;
        nhu = hu;
        nmt = mt;
        nmu = mu;
        case (sel_up)
            SEL_MIN_UNITS:  nmu = (mu == 4'd9) ? 4'd0 : mu + 4'd1;
            SEL_MIN_TENS:   nmt = (mt == 3'd5) ? 3'd0 : mt + 3'd1;
            SEL_HOUR_UNITS: begin
                if (ht == 2'd2) nhu = (hu == 4'd3) ? 4'd0 : hu + 4'd1;
                else            nhu = (hu == 4'd9) ? 4'd0 : hu + 4'd1;
            end
            SEL_HOUR_TENS:  begin
                nht = (ht == 2'd2) ? 2'd0 : ht + 2'd1;
                if (nht == 2'd2 && hu > 4'd3) nhu = 4'd3;
            end
            default: ;
        endcase
    end

    always_comb begin
        res                 = '0;
        sel_next            = sel_up;
        blink_phase_next    = blink_phase_reg;
        blink_stamp_next    = blink_stamp_reg;
        setting_stamp_next  = setting_stamp_reg;
        refresh_stamp_next  = refresh_stamp_reg;
        dot_phase_next      = dot_phase_reg;
        power_ok_stamp_next = power_ok_stamp_reg;
        sec_show            = item.cur_seconds;

        if (sel_reg == SEL_NONE) begin
            res.mask_valid   = 1'b1;
            blink_phase_next = 1'b1;
        end else if (blink_due) begin
            res.mask_valid   = 1'b1;
            res.digit_mask   = blink_phase_reg ? (4'b0001 << digit_sel) : 4'b0000;
            blink_phase_next = !blink_phase_reg;
            blink_stamp_next = now_s;
        end

        if (item.button_up) begin
            setting_stamp_next = now_s;
            blink_stamp_next   = '0;
            blink_phase_next   = 1'b1;
        end

        if (sel_up != SEL_NONE) begin
            if (item.button_down) begin
                setting_stamp_next = now_s;
                blink_stamp_next   = '0;
                blink_phase_next   = 1'b0;
                res.set_valid      = 1'b1;
                res.set_hours      = 5'(nht) * 5'd10 + 5'(nhu);
                res.set_minutes    = 6'(nmt) * 6'd10 + 6'(nmu);
                res.set_seconds    = seconds_c;
            end
            // a key press this poll restarts the timeout, so only idle polls expire
            if (!item.button_up && !item.button_down &&
                setting_elapsed > STAMP_BITS'(cfg.setting_timeout_ms)) begin
                sel_next = SEL_NONE;
            end
        end

        if (refresh_due) begin
            sec_show           = res.set_valid ? res.set_seconds : item.cur_seconds;
            refresh_stamp_next = now_s;
            res.show_valid     = 1'b1;
            res.show_hours     = res.set_valid ? res.set_hours : item.cur_hours;
            res.show_minutes   = res.set_valid ? res.set_minutes : item.cur_minutes;
            res.dots           = dot_phase_reg ?
                                 ((sec_show < HALF_MIN) ? DOTS_UPPER : DOTS_LOWER) : DOTS_BOTH;
            dot_phase_next     = !dot_phase_reg;
        end

        if (item.power_lost) begin
            res.shutdown_request = power_elapsed > STAMP_BITS'(cfg.shutdown_delay_ms);
        end else begin
            power_ok_stamp_next = now_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg            <= SEL_NONE;
            blink_phase_reg    <= 1'b0;
            dot_phase_reg      <= 1'b0;
            blink_stamp_reg    <= '0;
            setting_stamp_reg  <= '0;
            refresh_stamp_reg  <= '0;
            power_ok_stamp_reg <= '0;
        end else if (fire) begin
            sel_reg            <= sel_next;
            blink_phase_reg    <= blink_phase_next;
            dot_phase_reg      <= dot_phase_next;
            blink_stamp_reg    <= blink_stamp_next;
            setting_stamp_reg  <= setting_stamp_next;
            refresh_stamp_reg  <= refresh_stamp_next;
            power_ok_stamp_reg <= power_ok_stamp_next;
        end
    end

    a_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> $onehot0(res.digit_mask) && (res.mask_valid || res.digit_mask == 4'd0))
        else $error("digit mask blanks more than one digit");

    a_set_keeps_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.set_valid |=> sel_reg != SEL_NONE)
        else $error("time set ended the digit selection");

    a_refresh_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.show_valid |=> refresh_stamp_reg == $past(now_s))
        else $error("refresh stamp not taken on display update");

    a_dot_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.show_valid |=> dot_phase_reg != $past(dot_phase_reg))
        else $error("dot phase did not advance on display update");

    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg <= SEL_MIN_UNITS)
        else $error("selected digit out of range");

endmodule

[rtl/core/clock_panel_time_setter.sv]
// Top level: input word register, poll evaluation core and result word register.
// A held word's result is loaded into the result register once that register is free.
// Throughput: one word per cycle while m_tready takes each result; the combinational
//   poll evaluation in cpts_core between the two word registers sets this rate.
// Reset: aresetn is synchronous, active low; it empties both word registers,
//   clears the selection, phases and timer stamps, and restores the register defaults.
module clock_panel_time_setter import cpts_pkg::*; #(
    parameter int STAMP_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // fields from bit 0 up: now_ms[31:0], button_up, button_down, cur_hours[4:0],
    // cur_minutes[5:0], cur_seconds[5:0], power_lost, zero fill
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // fields from bit 0 up: mask_valid, digit_mask[3:0], set_valid, set_hours[4:0],
    // set_minutes[5:0], set_seconds[5:0], show_valid, show_hours[4:0],
    // show_minutes[5:0], dots[1:0], shutdown_request, zero fill
    output logic [M_TDATA_BITS-1:0]  m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t     cfg;
    in_item_t in_word;
    in_item_t in_item_reg;
    logic     in_valid_reg;
    result_t  res;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     fire;
    logic     out_free;

    // unpack the input word
    assign in_word.now_ms      = s_tdata[31:0];
    assign in_word.button_up   = s_tdata[32];
    assign in_word.button_down = s_tdata[33];
    assign in_word.cur_hours   = s_tdata[38:34];
    assign in_word.cur_minutes = s_tdata[44:39];
    assign in_word.cur_seconds = s_tdata[50:45];
    assign in_word.power_lost  = s_tdata[51];

    // result register frees up when empty or when its word is taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    // evaluate the held poll and advance state when the result can be stored
    assign fire     = in_valid_reg && out_free;
    // take a new word whenever the input register is empty or moving on
    assign s_tready = !in_valid_reg || fire;

    cpts_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpts_core #(
        .STAMP_BITS (STAMP_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= in_word;
        end
    end

    // result word register: load on fire, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.shutdown_request,
                       out_reg.dots,
                       out_reg.show_minutes,
                       out_reg.show_hours,
                       out_reg.show_valid,
                       out_reg.set_seconds,
                       out_reg.set_minutes,
                       out_reg.set_hours,
                       out_reg.set_valid,
                       out_reg.digit_mask,
                       out_reg.mask_valid};

endmodule
